### rtl/core/console_line_editor_assert.svh
// ----------------------------------------------------------------------------
// console_line_editor_assert.svh
// Assertion macros for the line editor checker.
// ----------------------------------------------------------------------------
`ifndef CONSOLE_LINE_EDITOR_ASSERT_SVH
`define CONSOLE_LINE_EDITOR_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define CLE_ASSERT_IMPLY(label, clk, rst_n, lhs, rhs) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (lhs) |-> (rhs)) \
		else $error("line editor assertion failed");

// Next-cycle implication, disabled in reset.
`define CLE_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (lhs) |=> (rhs)) \
		else $error("line editor assertion failed");

`endif

### rtl/core/cle_pkg.sv
// ----------------------------------------------------------------------------
// cle_pkg
// Character codes, result kinds and controller/datapath interface types.
// ----------------------------------------------------------------------------
package cle_pkg;

	localparam int BUFFER_DEPTH_DEF = 128;

	localparam logic [7:0] CH_NUL  = 8'h00;
	localparam logic [7:0] CH_EOF  = 8'h04;
	localparam logic [7:0] CH_BS   = 8'h08;
	localparam logic [7:0] CH_LF   = 8'h0A;
	localparam logic [7:0] CH_CR   = 8'h0D;
	localparam logic [7:0] CH_DLE  = 8'h10;
	localparam logic [7:0] CH_KILL = 8'h15;
	localparam logic [7:0] CH_DEL  = 8'h7F;

	typedef logic [2:0] kind_t;

	localparam kind_t KIND_IGNORED = 3'd0;
	localparam kind_t KIND_ECHO    = 3'd1;
	localparam kind_t KIND_ERASE   = 3'd2;
	localparam kind_t KIND_READ    = 3'd3;
	localparam kind_t KIND_EOF     = 3'd4;
	localparam kind_t KIND_EMPTY   = 3'd5;

	typedef struct packed {
		logic load;
		logic kill_addr;
		logic kill_step;
		logic emit_char;
		logic emit_read;
		logic emit_kill;
	} cmd_t;

	typedef struct packed {
		logic in_op;
		logic in_kill;
		logic out_free;
		logic ed_eq_cm;
		logic rdata_lf;
	} status_t;

endpackage

### rtl/core/cle_ctrl.sv
// ----------------------------------------------------------------------------
// cle_ctrl
// Sequencer: accepts a beat, walks kill erasure, and issues result commands.
// ----------------------------------------------------------------------------
module cle_ctrl import cle_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  status_t st,
	output cmd_t    cmd
);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_CHAR = 5'b00010,
		ST_RD   = 5'b00100,
		ST_KRD  = 5'b01000,
		ST_KCHK = 5'b10000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					if (st.in_op) begin
						state_d = ST_RD;
					end else if (st.in_kill) begin
						state_d = ST_KRD;
					end else begin
						state_d = ST_CHAR;
					end
				end
			end
			ST_CHAR: begin
				if (st.out_free) begin
					cmd.emit_char = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_RD: begin
				if (st.out_free) begin
					cmd.emit_read = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_KRD: begin
				cmd.kill_addr = 1'b1;
				if (st.ed_eq_cm) begin
					if (st.out_free) begin
						cmd.emit_kill = 1'b1;
						state_d = ST_IDLE;
					end
				end else begin
					state_d = ST_KCHK;
				end
			end
			ST_KCHK: begin
				cmd.kill_addr = 1'b1;
				if (st.rdata_lf) begin
					if (st.out_free) begin
						cmd.emit_kill = 1'b1;
						state_d = ST_IDLE;
					end
				end else begin
					cmd.kill_step = 1'b1;
					state_d = ST_KRD;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

### rtl/core/cle_dpath.sv
// ----------------------------------------------------------------------------
// cle_dpath
// Line store, read/commit/edit indices, kill counter and result register.
// ----------------------------------------------------------------------------
module cle_dpath import cle_pkg::*; #(
	parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [15:0] s_tdata,
	input  logic        s_tuser,
	input  cmd_t        cmd,
	output status_t     st,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,
	output logic        m_tlast,
	output logic [2:0]  m_tuser
);

	localparam int IW = $clog2(2 * BUFFER_DEPTH);
	localparam int SW = $clog2(BUFFER_DEPTH);
	localparam int CW = $clog2(BUFFER_DEPTH + 1);
	localparam logic [IW-1:0] IDX_LAST = IW'(2 * BUFFER_DEPTH - 1);
	localparam logic [IW:0]   IDX_MOD  = (IW + 1)'(2 * BUFFER_DEPTH);
	localparam logic [IW-1:0] IDX_DEPTH = IW'(BUFFER_DEPTH);

	function automatic logic [IW-1:0] idx_inc(input logic [IW-1:0] x);
		return (x == IDX_LAST) ? '0 : x + 1'b1;
	endfunction

	function automatic logic [IW-1:0] idx_dec(input logic [IW-1:0] x);
		return (x == '0) ? IDX_LAST : x - 1'b1;
	endfunction

	function automatic logic [IW-1:0] idx_diff(input logic [IW-1:0] a, input logic [IW-1:0] b);
		logic [IW:0] t;
		t = (a >= b) ? {1'b0, a - b} : ({1'b0, a} + IDX_MOD - {1'b0, b});
		return t[IW-1:0];
	endfunction

	function automatic logic [SW-1:0] slot(input logic [IW-1:0] x);
		logic [IW-1:0] t;
		t = (x >= IDX_DEPTH) ? x - IDX_DEPTH : x;
		return t[SW-1:0];
	endfunction

	logic [7:0]    mem_q [BUFFER_DEPTH];
	logic [7:0]    rdata_q;
	logic [IW-1:0] rd_q, cm_q, ed_q;
	logic          first_q;
	logic [7:0]    ch_q;
	logic [CW-1:0] count_q;

	logic          m_tvalid_q;
	kind_t         kind_q;
	logic [7:0]    data_q, cnt_q;
	logic          lend_q, comm_q;

	logic          out_free;
	logic [SW-1:0] raddr;
	logic          is_bs, full, store, commit_now, bs_erase;
	logic [7:0]    c_st;
	logic [IW-1:0] ed_inc;
	logic          rd_empty, rd_eof;
	kind_t         kind_d;
	logic [7:0]    data_d, cnt_d;
	logic          lend_d, comm_d, emit;

	assign out_free = !m_tvalid_q || m_tready;
	assign raddr = cmd.kill_addr ? slot(idx_dec(ed_q)) : slot(rd_q);

	assign st.in_op    = s_tuser;
	assign st.in_kill  = (s_tdata[7:0] == CH_KILL);
	assign st.out_free = out_free;
	assign st.ed_eq_cm = (ed_q == cm_q);
	assign st.rdata_lf = (rdata_q == CH_LF);

	always_comb begin
		is_bs = (ch_q == CH_BS) || (ch_q == CH_DEL);
		full = (idx_diff(ed_q, rd_q) == IDX_DEPTH);
		store = !is_bs && (ch_q != CH_NUL) && (ch_q != CH_DLE) && !full;
		bs_erase = is_bs && (ed_q != cm_q);
		c_st = (ch_q == CH_CR) ? CH_LF : ch_q;
		ed_inc = idx_inc(ed_q);
		commit_now = store && ((c_st == CH_LF) || (c_st == CH_EOF) ||
			(idx_diff(ed_inc, rd_q) == IDX_DEPTH));
		rd_empty = (rd_q == cm_q);
		rd_eof = (rdata_q == CH_EOF);
	end

	always_comb begin
		kind_d = KIND_IGNORED;
		data_d = '0;
		cnt_d = '0;
		lend_d = 1'b0;
		comm_d = 1'b0;
		emit = cmd.emit_char || cmd.emit_read || cmd.emit_kill;
		if (cmd.emit_char) begin
			if (bs_erase) begin
				kind_d = KIND_ERASE;
				cnt_d = 8'd1;
			end else if (store) begin
				kind_d = KIND_ECHO;
				data_d = c_st;
				comm_d = commit_now;
			end
		end else if (cmd.emit_read) begin
			if (rd_empty) begin
				kind_d = KIND_EMPTY;
			end else if (rd_eof) begin
				kind_d = KIND_EOF;
			end else begin
				kind_d = KIND_READ;
				data_d = rdata_q;
				lend_d = (rdata_q == CH_LF);
			end
		end else if (cmd.emit_kill) begin
			if (count_q != '0) begin
				kind_d = KIND_ERASE;
				cnt_d = (32'(count_q) > 32'd255) ? 8'hFF : 8'(count_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_char && store) begin
			mem_q[slot(ed_q)] <= c_st;
		end
		rdata_q <= mem_q[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= '0;
			cm_q <= '0;
			ed_q <= '0;
			count_q <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				count_q <= '0;
			end
			if (cmd.kill_step) begin
				ed_q <= idx_dec(ed_q);
				count_q <= count_q + 1'b1;
			end
			if (cmd.emit_char) begin
				if (bs_erase) begin
					ed_q <= idx_dec(ed_q);
				end else if (store) begin
					ed_q <= ed_inc;
					if (commit_now) begin
						cm_q <= ed_inc;
					end
				end
			end
			if (cmd.emit_read && !rd_empty && (!rd_eof || first_q)) begin
				rd_q <= idx_inc(rd_q);
			end
			if (emit) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ch_q <= s_tdata[7:0];
			first_q <= s_tdata[8];
		end
		if (emit) begin
			kind_q <= kind_d;
			data_q <= data_d;
			cnt_q <= cnt_d;
			lend_q <= lend_d;
			comm_q <= comm_d;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser = kind_q;
	assign m_tlast = lend_q;
	assign m_tdata = {7'b0, comm_q, cnt_q, data_q};

endmodule

### rtl/core/console_line_editor.sv
// ----------------------------------------------------------------------------
// console_line_editor
// Canonical terminal line editor on a circular byte store.
// ----------------------------------------------------------------------------
// A received character or a read request is taken as one input beat and
// answered by exactly one result beat. Ordinary characters, backspace and
// read requests then wait in ST_CHAR or ST_RD until the output is free and
// the result is registered; a kill walks the edit index back with one
// registered read of the line store per character walked back, through
// the single read port of the store. No clearing pass runs after reset; the
// store holds no valid data until written. A new beat is taken only when the
// previous one is finished, while its result may still wait in the output
// register; a result not yet taken holds the next one back and stretches its
// item by the cycles of the stall.
module console_line_editor import cle_pkg::*; #(
	parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // rx_char[7:0], first_of_read[8], zero[15:9]
	input  logic        s_tuser,  // op[0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // data[7:0], erase_count[15:8], committed[16], zero[23:17]
	output logic        m_tlast,  // line_end
	output logic [2:0]  m_tuser   // kind[2:0]
);

	cmd_t    cmd;
	status_t st;

	cle_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	cle_dpath #(
		.BUFFER_DEPTH (BUFFER_DEPTH)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.cmd      (cmd),
		.st       (st),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule

### rtl/core/cle_checker.sv
// ----------------------------------------------------------------------------
// cle_checker
// Port-level checks on the line editor, bound to the top level.
// ----------------------------------------------------------------------------
`include "console_line_editor_assert.svh"

module cle_checker import cle_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata,
	input logic        m_tlast,
	input logic [2:0]  m_tuser
);

	`CLE_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
	`CLE_ASSERT_NEXT(a_one_at_a_time, clk, arst_n, s_tvalid && s_tready, !s_tready)
	`CLE_ASSERT_IMPLY(a_line_end_read, clk, arst_n, m_tvalid && m_tlast, (m_tuser == KIND_READ) && (m_tdata[7:0] == CH_LF))
	`CLE_ASSERT_IMPLY(a_commit_echo, clk, arst_n, m_tvalid && m_tdata[16], m_tuser == KIND_ECHO)

endmodule

bind console_line_editor cle_checker u_cle_checker (.*);

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the console line editor. A queue of beats
// (received characters and read requests) is built up front: a short
// directed run through the editing commands, ignored characters, commits,
// end of file and the empty reader, then random typed lines with edits,
// reads, store floods and noise. A clocked driver feeds the queue into the
// slave side with random gaps. A clocked monitor takes results on the
// master side with random stalls. It checks each result against a
// prediction of the line discipline kept inside the bench.
// ----------------------------------------------------------------------------
module tb_top;
	import cle_pkg::*;

	localparam int          LIMIT      = 1000000;
	localparam int          DRAIN      = 300;
	localparam int          RAND_BEATS = 1350;
	localparam logic [7:0]  STORE_FULL = 8'd128;
	localparam bit          OP_RX      = 1'b0;
	localparam bit          OP_READ    = 1'b1;

	typedef struct packed {
		logic       op;
		logic [7:0] ch;
		logic       first;
	} beat_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
		logic [7:0] count;
		logic       line_end;
		logic       committed;
	} result_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata  = '0;
	logic        s_tuser  = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic        m_tlast;
	logic [2:0]  m_tuser;

	beat_t   tty_beats[$];
	result_t pending_results[$];
	logic    s_fire = 1'b0;
	logic    quiet  = 1'b0;
	int      errors = 0;
	int      cycles = 0;
	int      gap_left = 0;
	int      stall_left = 0;
	beat_t   next_beat;

	logic [7:0] line_buf [0:127];
	logic [7:0] rd_idx = '0;
	logic [7:0] cm_idx = '0;
	logic [7:0] ed_idx = '0;

	console_line_editor u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic result_t discipline_step(beat_t b);
		result_t     r;
		logic [7:0]  ch;
		logic [7:0]  prev;
		logic [7:0]  fill;
		int unsigned n;
		r = '0;
		ch = b.ch;
		n = 0;
		if (b.op == OP_RX) begin
			fill = ed_idx - rd_idx;
			if (ch == CH_KILL) begin
				prev = ed_idx - 8'd1;
				while (ed_idx != cm_idx && line_buf[prev[6:0]] != CH_LF) begin
					ed_idx = prev;
					prev = ed_idx - 8'd1;
					n++;
				end
				if (n != 0)
					r.kind = KIND_ERASE;
			end else if (ch == CH_BS || ch == CH_DEL) begin
				if (ed_idx != cm_idx) begin
					ed_idx = ed_idx - 8'd1;
					n = 1;
					r.kind = KIND_ERASE;
				end
			end else if (ch != CH_NUL && ch != CH_DLE && fill < STORE_FULL) begin
				if (ch == CH_CR)
					ch = CH_LF;
				line_buf[ed_idx[6:0]] = ch;
				ed_idx = ed_idx + 8'd1;
				r.kind = KIND_ECHO;
				r.data = ch;
				fill = ed_idx - rd_idx;
				if (ch == CH_LF || ch == CH_EOF || fill == STORE_FULL) begin
					cm_idx = ed_idx;
					r.committed = 1'b1;
				end
			end
		end else if (rd_idx == cm_idx) begin
			r.kind = KIND_EMPTY;
		end else if (line_buf[rd_idx[6:0]] == CH_EOF) begin
			r.kind = KIND_EOF;
			if (b.first)
				rd_idx = rd_idx + 8'd1;
		end else begin
			r.kind = KIND_READ;
			r.data = line_buf[rd_idx[6:0]];
			r.line_end = (r.data == CH_LF);
			rd_idx = rd_idx + 8'd1;
		end
		r.count = (n > 255) ? 8'd255 : n[7:0];
		return r;
	endfunction

	function automatic int pause_len();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic push_beat(logic op, logic [7:0] ch, logic first);
		beat_t b;
		b.op = op;
		b.ch = ch;
		b.first = first;
		tty_beats.push_back(b);
	endtask

	task automatic type_line(int len, int reads);
		int r;
		for (int i = 0; i < len; i++) begin
			r = $urandom_range(0, 99);
			if (r < 10)
				push_beat(OP_RX, $urandom_range(0, 1) ? CH_BS : CH_DEL,
					1'($urandom_range(0, 1)));
			else if (r < 13)
				push_beat(OP_RX, CH_KILL, 1'($urandom_range(0, 1)));
			else if (r < 22)
				push_beat(OP_RX, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
			else
				push_beat(OP_RX, 8'($urandom_range(8'h20, 8'h7e)), 1'($urandom_range(0, 1)));
		end
		r = $urandom_range(0, 99);
		push_beat(OP_RX, (r < 50) ? CH_LF : (r < 80) ? CH_CR : CH_EOF,
			1'($urandom_range(0, 1)));
		for (int i = 0; i < reads; i++)
			push_beat(OP_READ, 8'($urandom_range(0, 255)),
				(i == 0) || ($urandom_range(0, 9) < 3));
	endtask

	// driver: hold the beat until taken, then advance after a random gap
	always @(negedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || s_fire) begin
			if (gap_left != 0) begin
				s_tvalid <= 1'b0;
				gap_left--;
			end else if (tty_beats.size() != 0) begin
				next_beat = tty_beats.pop_front();
				s_tvalid <= 1'b1;
				s_tuser <= next_beat.op;
				s_tdata <= {7'd0, next_beat.first, next_beat.ch};
				gap_left = pause_len();
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (stall_left != 0) begin
			m_tready <= 1'b0;
			stall_left--;
		end else begin
			m_tready <= 1'b1;
			if ($urandom_range(0, 3) == 0)
				stall_left = pause_len();
		end
	end

	always @(posedge clk) begin
		beat_t b;
		s_fire <= arst_n && s_tvalid && s_tready;
		if (arst_n && s_tvalid && s_tready) begin
			b.op = s_tuser;
			b.ch = s_tdata[7:0];
			b.first = s_tdata[8];
			pending_results.push_back(discipline_step(b));
		end
	end

	// monitor: compare each result beat with the oldest prediction
	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.kind = m_tuser;
			got.data = m_tdata[7:0];
			got.count = m_tdata[15:8];
			got.committed = m_tdata[16];
			got.line_end = m_tlast;
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t unexpected result: kind %0d data %h count %0d last %b comm %b",
					$time, got.kind, got.data, got.count, got.line_end, got.committed);
			end else begin
				want = pending_results.pop_front();
				if (got !== want) begin
					errors++;
					$display("%0t mismatch: expected kind %0d data %h count %0d last %b comm %b",
						$time, want.kind, want.data, want.count, want.line_end,
						want.committed);
					$display("%0t          actual   kind %0d data %h count %0d last %b comm %b",
						$time, got.kind, got.data, got.count, got.line_end, got.committed);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles % 256 == 0)
			quiet <= ($urandom_range(0, 3) == 0);
		if (cycles == LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		int r;
		int len;
		int base;
		push_beat(OP_READ, 8'hFF, 1'b1);
		push_beat(OP_READ, 8'h00, 1'b0);
		push_beat(OP_RX, CH_BS, 1'b1);
		push_beat(OP_RX, CH_DEL, 1'b0);
		push_beat(OP_RX, CH_KILL, 1'b0);
		push_beat(OP_RX, CH_NUL, 1'b0);
		push_beat(OP_RX, CH_DLE, 1'b1);
		push_beat(OP_RX, 8'h61, 1'b0);
		push_beat(OP_RX, 8'hFF, 1'b0);
		push_beat(OP_RX, 8'h80, 1'b0);
		push_beat(OP_RX, CH_BS, 1'b0);
		push_beat(OP_RX, CH_KILL, 1'b0);
		push_beat(OP_RX, 8'h78, 1'b0);
		push_beat(OP_RX, CH_CR, 1'b0);
		push_beat(OP_READ, 8'h00, 1'b1);
		push_beat(OP_READ, 8'h00, 1'b0);
		push_beat(OP_RX, CH_EOF, 1'b0);
		push_beat(OP_READ, 8'h00, 1'b0);
		push_beat(OP_READ, 8'h00, 1'b1);
		push_beat(OP_READ, 8'h00, 1'b1);
		push_beat(OP_RX, 8'h7a, 1'b0);
		push_beat(OP_RX, CH_LF, 1'b1);
		push_beat(OP_RX, CH_BS, 1'b0);
		push_beat(OP_READ, 8'h00, 1'b1);
		push_beat(OP_READ, 8'h00, 1'b0);

		base = tty_beats.size();
		while (tty_beats.size() - base < RAND_BEATS) begin
			r = $urandom_range(0, 99);
			if (r < 72) begin
				len = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 60) : $urandom_range(0, 12);
				type_line(len, ($urandom_range(0, 3) == 0) ? $urandom_range(0, len) : len + 2);
			end else if (r < 76) begin
				len = 128 + $urandom_range(0, 12);
				for (int i = 0; i < len; i++)
					push_beat(OP_RX, 8'($urandom_range(8'h20, 8'h7e)),
						1'($urandom_range(0, 1)));
				push_beat(OP_RX, CH_BS, 1'b0);
				push_beat(OP_RX, CH_KILL, 1'b1);
				for (int i = 0; i < 140; i++)
					push_beat(OP_READ, 8'($urandom_range(0, 255)), 1'b1);
			end else begin
				len = $urandom_range(1, 6);
				for (int i = 0; i < len; i++)
					push_beat(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
						1'($urandom_range(0, 1)));
			end
		end

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (tty_beats.size() != 0 || s_tvalid || pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
